// ----- rtl/sdcc_pkg.sv -----
// Package for the stick dead-zone and circular-clamp unit: widths, constants, sideband type.
package sdcc_pkg;

    // Widths of the fixed datapath (sized for an output limit of up to 127)
    localparam int RAW_W     = 16;   // raw axis sample
    localparam int FB_W      = 8;    // fallback and output axis
    localparam int DZ_W      = 15;   // dead-zone register
    localparam int MAG_W     = 17;   // magnitude of a raw axis after negation
    localparam int LIMV_W    = 7;    // output limit value
    localparam int PROD_W    = 22;   // magnitude times limit
    localparam int FS_SHIFT  = 15;   // 32767 is 2**15 - 1
    localparam int REM_W     = 16;
    localparam int SCL_W     = 7;    // scaled magnitude
    localparam int SQ_W      = 14;   // square of a scaled magnitude
    localparam int LEN_W     = 15;   // squared length of the pair
    localparam int LIM_W     = 28;   // (scaled magnitude * limit) squared
    localparam int ACC_W     = 24;   // root * len2
    localparam int TRIAL_W   = 32;   // trial product in the root search
    localparam int ROOT_STEPS = SCL_W;

    localparam logic [REM_W-1:0] FULL_SCALE = 16'd32767;
    localparam logic [DZ_W-1:0]  DEAD_RESET = 15'd5000;

    // Stages before the root search, the search itself, and the output register
    localparam int PRE_STAGES = 5;
    localparam int PIPE_DEPTH = PRE_STAGES + ROOT_STEPS;
    localparam int LATENCY    = PIPE_DEPTH + 1;

    // Per-beat sideband that travels next to the datapath
    typedef struct packed {
        logic                   neg_x;
        logic                   neg_y;
        logic                   rest;
        logic                   clamp;
        logic [SCL_W-1:0]       sx;
        logic [SCL_W-1:0]       sy;
        logic signed [FB_W-1:0] fb_x;
        logic signed [FB_W-1:0] fb_y;
    } side_t;

endpackage

// ----- rtl/sdcc_circle_root.sv -----
// Pipelined root search: largest q with q*q*len2 <= lim, one bit per stage.
module sdcc_circle_root (
    input  logic                        clk,
    input  logic [sdcc_pkg::LEN_W-1:0]  len2,
    input  logic [sdcc_pkg::LIM_W-1:0]  lim,
    output logic [sdcc_pkg::SCL_W-1:0]  root
);

    localparam int STEPS = sdcc_pkg::ROOT_STEPS;

    logic [sdcc_pkg::SCL_W-1:0] q_reg    [0:STEPS-1];
    logic [sdcc_pkg::LIM_W-1:0] p_reg    [0:STEPS-2];
    logic [sdcc_pkg::ACC_W-1:0] acc_reg  [0:STEPS-2];
    logic [sdcc_pkg::LEN_W-1:0] len2_reg [0:STEPS-2];
    logic [sdcc_pkg::LIM_W-1:0] lim_reg  [0:STEPS-2];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam int K = STEPS - 1 - i;

        logic [sdcc_pkg::SCL_W-1:0]   q_cur;
        logic [sdcc_pkg::LIM_W-1:0]   p_cur;
        logic [sdcc_pkg::ACC_W-1:0]   acc_cur;
        logic [sdcc_pkg::LEN_W-1:0]   len_cur;
        logic [sdcc_pkg::LIM_W-1:0]   lim_cur;
        logic [sdcc_pkg::TRIAL_W-1:0] trial;
        logic                         fit;
        logic [sdcc_pkg::SCL_W-1:0]   q_next;
        logic [sdcc_pkg::LIM_W-1:0]   p_next;
        logic [sdcc_pkg::ACC_W-1:0]   acc_next;

        if (i == 0) begin : g_first
            assign q_cur   = '0;
            assign p_cur   = '0;
            assign acc_cur = '0;
            assign len_cur = len2;
            assign lim_cur = lim;
        end else begin : g_rest
            assign q_cur   = q_reg[i-1];
            assign p_cur   = p_reg[i-1];
            assign acc_cur = acc_reg[i-1];
            assign len_cur = len2_reg[i-1];
            assign lim_cur = lim_reg[i-1];
        end

        // (q + 2^K)^2 * len2 = q^2*len2 + (q*len2) << (K+1) + len2 << 2K
        always_comb
        begin
            trial = sdcc_pkg::TRIAL_W'(p_cur)
                  + (sdcc_pkg::TRIAL_W'(acc_cur) << (K + 1))
                  + (sdcc_pkg::TRIAL_W'(len_cur) << (2 * K));
            fit   = (trial <= sdcc_pkg::TRIAL_W'(lim_cur));
            if (fit)
            begin
                q_next   = q_cur | (sdcc_pkg::SCL_W'(1) << K);
                p_next   = trial[sdcc_pkg::LIM_W-1:0];
                acc_next = acc_cur + (sdcc_pkg::ACC_W'(len_cur) << K);
            end
            else
            begin
                q_next   = q_cur;
                p_next   = p_cur;
                acc_next = acc_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            q_reg[i] <= q_next;
        end

        if (i < STEPS - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                p_reg[i]    <= p_next;
                acc_reg[i]  <= acc_next;
                len2_reg[i] <= len_cur;
                lim_reg[i]  <= lim_cur;
            end
        end
    end

    assign root = q_reg[STEPS-1];

endmodule

// ----- rtl/stick_deadzone_circular_clamp_unit.sv -----
// Top level of the stick dead-zone and circular-clamp unit.
// A beat accepted at a clock edge runs through every stage and the output
// register, and its result then shows on the outputs, marked by done.
// Throughput: one beat per cycle; busy stays low, the pipeline never stalls.
// The depth is set by five conditioning/scaling stages plus the seven-stage
// bit-per-stage root search that pulls a long vector onto the circle.
// Reset (rst_n low, asynchronous): flush all in-flight beats, dead zone = 5000.
module stick_deadzone_circular_clamp_unit #(
    parameter int OUT_LIMIT = 100
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command channel
    input  logic                               start,
    output logic                               busy,
    input  logic signed [sdcc_pkg::RAW_W-1:0]  raw_x,
    input  logic signed [sdcc_pkg::RAW_W-1:0]  raw_y,
    input  logic signed [sdcc_pkg::FB_W-1:0]   fallback_x,
    input  logic signed [sdcc_pkg::FB_W-1:0]   fallback_y,
    // result channel
    output logic                               done,
    output logic signed [sdcc_pkg::FB_W-1:0]   stick_x,
    output logic signed [sdcc_pkg::FB_W-1:0]   stick_y,
    output logic                               active,
    // dead-zone register write
    input  logic                               cfg_we,
    input  logic [sdcc_pkg::DZ_W-1:0]          cfg_data
);

    localparam int DEPTH = sdcc_pkg::PIPE_DEPTH;
    localparam int STEPS = sdcc_pkg::ROOT_STEPS;
    localparam logic [sdcc_pkg::LEN_W-1:0] LIMIT_SQ =
        sdcc_pkg::LEN_W'(OUT_LIMIT * OUT_LIMIT);

    // ---------------------------------------------------------------
    // Dead-zone register
    // ---------------------------------------------------------------
    logic [sdcc_pkg::DZ_W-1:0] dead_zone_reg;
    logic [sdcc_pkg::DZ_W-1:0] dead_zone_next;

    always_comb
    begin
        dead_zone_next = cfg_we ? cfg_data : dead_zone_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dead_zone_reg <= sdcc_pkg::DEAD_RESET;
        else
            dead_zone_reg <= dead_zone_next;
    end

    // ---------------------------------------------------------------
    // Valid line: one bit per stage, shifted every cycle
    // ---------------------------------------------------------------
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic             accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        vld_next = {vld_reg[DEPTH-2:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // ---------------------------------------------------------------
    // Stage 1: negate Y, take magnitudes, apply the dead zone
    // ---------------------------------------------------------------
    logic signed [sdcc_pkg::MAG_W-1:0] mx_s;
    logic signed [sdcc_pkg::MAG_W-1:0] my_s;
    logic [sdcc_pkg::MAG_W-1:0]        ax_raw;
    logic [sdcc_pkg::MAG_W-1:0]        ay_raw;
    logic [sdcc_pkg::MAG_W-1:0]        ax_dz;
    logic [sdcc_pkg::MAG_W-1:0]        ay_dz;
    logic [sdcc_pkg::MAG_W-1:0]        dz_ext;
    sdcc_pkg::side_t                   side0;

    logic [sdcc_pkg::MAG_W-1:0] ax1_reg;
    logic [sdcc_pkg::MAG_W-1:0] ay1_reg;
    sdcc_pkg::side_t            side1_reg;

    always_comb
    begin
        mx_s   = sdcc_pkg::MAG_W'(raw_x);
        my_s   = -sdcc_pkg::MAG_W'(raw_y);
        ax_raw = mx_s[sdcc_pkg::MAG_W-1] ? sdcc_pkg::MAG_W'(-mx_s) : sdcc_pkg::MAG_W'(mx_s);
        ay_raw = my_s[sdcc_pkg::MAG_W-1] ? sdcc_pkg::MAG_W'(-my_s) : sdcc_pkg::MAG_W'(my_s);
        dz_ext = sdcc_pkg::MAG_W'(dead_zone_reg);
        // drop an axis whose magnitude sits strictly inside the dead zone
        ax_dz  = (ax_raw < dz_ext) ? '0 : ax_raw;
        ay_dz  = (ay_raw < dz_ext) ? '0 : ay_raw;

        side0       = '0;
        side0.neg_x = mx_s[sdcc_pkg::MAG_W-1];
        side0.neg_y = my_s[sdcc_pkg::MAG_W-1];
        side0.rest  = (ax_dz == '0) && (ay_dz == '0);
        side0.fb_x  = fallback_x;
        side0.fb_y  = fallback_y;
    end

    always_ff @(posedge clk)
    begin
        ax1_reg   <= ax_dz;
        ay1_reg   <= ay_dz;
        side1_reg <= side0;
    end

    // ---------------------------------------------------------------
    // Stage 2: magnitude times the output limit
    // ---------------------------------------------------------------
    logic [sdcc_pkg::PROD_W-1:0] px2_reg;
    logic [sdcc_pkg::PROD_W-1:0] py2_reg;
    sdcc_pkg::side_t             side2_reg;

    always_ff @(posedge clk)
    begin
        px2_reg   <= sdcc_pkg::PROD_W'(ax1_reg) * sdcc_pkg::PROD_W'(OUT_LIMIT);
        py2_reg   <= sdcc_pkg::PROD_W'(ay1_reg) * sdcc_pkg::PROD_W'(OUT_LIMIT);
        side2_reg <= side1_reg;
    end

    // ---------------------------------------------------------------
    // Stage 3: divide by 32767. Take p >> 15 as the first guess; the
    // remainder against 32767 is then (p mod 2^15) + guess, which needs
    // at most one correction step.
    // ---------------------------------------------------------------
    logic [sdcc_pkg::SCL_W-1:0] qx0;
    logic [sdcc_pkg::SCL_W-1:0] qy0;
    logic [sdcc_pkg::REM_W-1:0] rx;
    logic [sdcc_pkg::REM_W-1:0] ry;
    sdcc_pkg::side_t            side3_next;
    sdcc_pkg::side_t            side3_reg;

    always_comb
    begin
        qx0 = px2_reg[sdcc_pkg::PROD_W-1:sdcc_pkg::FS_SHIFT];
        qy0 = py2_reg[sdcc_pkg::PROD_W-1:sdcc_pkg::FS_SHIFT];
        rx  = sdcc_pkg::REM_W'(px2_reg[sdcc_pkg::FS_SHIFT-1:0]) + sdcc_pkg::REM_W'(qx0);
        ry  = sdcc_pkg::REM_W'(py2_reg[sdcc_pkg::FS_SHIFT-1:0]) + sdcc_pkg::REM_W'(qy0);
        side3_next    = side2_reg;
        side3_next.sx = qx0 + sdcc_pkg::SCL_W'(rx >= sdcc_pkg::FULL_SCALE);
        side3_next.sy = qy0 + sdcc_pkg::SCL_W'(ry >= sdcc_pkg::FULL_SCALE);
    end

    always_ff @(posedge clk)
    begin
        side3_reg <= side3_next;
    end

    // ---------------------------------------------------------------
    // Stage 4: squares, and scaled magnitude times the limit
    // ---------------------------------------------------------------
    logic [sdcc_pkg::SQ_W-1:0] sqx4_reg;
    logic [sdcc_pkg::SQ_W-1:0] sqy4_reg;
    logic [sdcc_pkg::SQ_W-1:0] slx4_reg;
    logic [sdcc_pkg::SQ_W-1:0] sly4_reg;
    sdcc_pkg::side_t           side4_reg;

    always_ff @(posedge clk)
    begin
        sqx4_reg  <= sdcc_pkg::SQ_W'(side3_reg.sx) * sdcc_pkg::SQ_W'(side3_reg.sx);
        sqy4_reg  <= sdcc_pkg::SQ_W'(side3_reg.sy) * sdcc_pkg::SQ_W'(side3_reg.sy);
        slx4_reg  <= sdcc_pkg::SQ_W'(side3_reg.sx) * sdcc_pkg::SQ_W'(OUT_LIMIT);
        sly4_reg  <= sdcc_pkg::SQ_W'(side3_reg.sy) * sdcc_pkg::SQ_W'(OUT_LIMIT);
        side4_reg <= side3_reg;
    end

    // ---------------------------------------------------------------
    // Stage 5: squared length, clamp decision, per-axis search bound
    // ---------------------------------------------------------------
    logic [sdcc_pkg::LEN_W-1:0] len2_5;
    sdcc_pkg::side_t            side5_next;
    logic [sdcc_pkg::LEN_W-1:0] len2_5_reg;
    logic [sdcc_pkg::LIM_W-1:0] limx5_reg;
    logic [sdcc_pkg::LIM_W-1:0] limy5_reg;
    sdcc_pkg::side_t            side5_reg;

    always_comb
    begin
        len2_5           = sdcc_pkg::LEN_W'(sqx4_reg) + sdcc_pkg::LEN_W'(sqy4_reg);
        side5_next       = side4_reg;
        side5_next.clamp = (len2_5 > LIMIT_SQ);
    end

    always_ff @(posedge clk)
    begin
        len2_5_reg <= len2_5;
        limx5_reg  <= sdcc_pkg::LIM_W'(slx4_reg) * sdcc_pkg::LIM_W'(slx4_reg);
        limy5_reg  <= sdcc_pkg::LIM_W'(sly4_reg) * sdcc_pkg::LIM_W'(sly4_reg);
        side5_reg  <= side5_next;
    end

    // ---------------------------------------------------------------
    // Stages 6..12: root search for each axis, sideband follows alongside
    // ---------------------------------------------------------------
    logic [sdcc_pkg::SCL_W-1:0] rootx;
    logic [sdcc_pkg::SCL_W-1:0] rooty;
    sdcc_pkg::side_t            side_pipe_reg [0:STEPS-1];

    sdcc_circle_root u_root_x (
        .clk  (clk),
        .len2 (len2_5_reg),
        .lim  (limx5_reg),
        .root (rootx)
    );

    sdcc_circle_root u_root_y (
        .clk  (clk),
        .len2 (len2_5_reg),
        .lim  (limy5_reg),
        .root (rooty)
    );

    always_ff @(posedge clk)
    begin
        side_pipe_reg[0] <= side5_reg;
        for (int i = 1; i < STEPS; i++)
        begin
            side_pipe_reg[i] <= side_pipe_reg[i-1];
        end
    end

    // ---------------------------------------------------------------
    // Output register: pick fallback, plain scale or clamped root, add sign
    // ---------------------------------------------------------------
    sdcc_pkg::side_t                   side_end;
    logic [sdcc_pkg::SCL_W-1:0]        magx;
    logic [sdcc_pkg::SCL_W-1:0]        magy;
    logic signed [sdcc_pkg::FB_W-1:0]  valx;
    logic signed [sdcc_pkg::FB_W-1:0]  valy;
    logic signed [sdcc_pkg::FB_W-1:0]  stick_x_next;
    logic signed [sdcc_pkg::FB_W-1:0]  stick_y_next;
    logic                              active_next;
    logic signed [sdcc_pkg::FB_W-1:0]  stick_x_reg;
    logic signed [sdcc_pkg::FB_W-1:0]  stick_y_reg;
    logic                              active_reg;
    logic                              done_reg;

    always_comb
    begin
        side_end = side_pipe_reg[STEPS-1];
        magx     = side_end.clamp ? rootx : side_end.sx;
        magy     = side_end.clamp ? rooty : side_end.sy;
        valx     = side_end.neg_x ? -sdcc_pkg::FB_W'(magx) : sdcc_pkg::FB_W'(magx);
        valy     = side_end.neg_y ? -sdcc_pkg::FB_W'(magy) : sdcc_pkg::FB_W'(magy);
        if (side_end.rest)
        begin
            stick_x_next = side_end.fb_x;
            stick_y_next = side_end.fb_y;
            active_next  = 1'b0;
        end
        else
        begin
            stick_x_next = valx;
            stick_y_next = valy;
            active_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        stick_x_reg <= stick_x_next;
        stick_y_reg <= stick_y_next;
        active_reg  <= active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[DEPTH-1];
    end

    assign done    = done_reg;
    assign stick_x = stick_x_reg;
    assign stick_y = stick_y_reg;
    assign active  = active_reg;

endmodule

// ----- rtl/sdcc_checker.sv -----
// Port-level checker for the stick dead-zone and circular-clamp unit, with its bind.
module sdcc_checker #(
    parameter int OUT_LIMIT = 100
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic signed [sdcc_pkg::RAW_W-1:0]  raw_x,
    input logic signed [sdcc_pkg::FB_W-1:0]   fallback_x,
    input logic signed [sdcc_pkg::FB_W-1:0]   fallback_y,
    input logic                               done,
    input logic signed [sdcc_pkg::FB_W-1:0]   stick_x,
    input logic signed [sdcc_pkg::FB_W-1:0]   stick_y,
    input logic                               active
);

    localparam int LAT = sdcc_pkg::LATENCY;
    localparam logic signed [sdcc_pkg::FB_W-1:0] LIM_P = sdcc_pkg::FB_W'(OUT_LIMIT);
    localparam logic signed [sdcc_pkg::FB_W-1:0] LIM_N = -sdcc_pkg::FB_W'(OUT_LIMIT);

    // every accepted beat yields its result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted beat produced no result at the expected cycle");

    // no result without a beat accepted the latency before
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching accepted beat");

    // a resting stick passes the fallback pair of the same beat
    a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !active) |->
            (stick_x == $past(fallback_x, LAT)) && (stick_y == $past(fallback_y, LAT)))
        else $error("fallback pair not passed through");

    // an active result stays within the output limit on both axes
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && active) |->
            (stick_x <= LIM_P) && (stick_x >= LIM_N) && (stick_y <= LIM_P) && (stick_y >= LIM_N))
        else $error("active result outside the output limit");

    // a centered X sample reads as zero on X
    a_x_center: assert property (@(posedge clk) disable iff (!rst_n)
        (done && active && ($past(raw_x, LAT) == '0)) |-> (stick_x == '0))
        else $error("centered X sample gave a nonzero X output");

endmodule

bind stick_deadzone_circular_clamp_unit sdcc_checker #(
    .OUT_LIMIT (OUT_LIMIT)
) u_sdcc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .raw_x      (raw_x),
    .fallback_x (fallback_x),
    .fallback_y (fallback_y),
    .done       (done),
    .stick_x    (stick_x),
    .stick_y    (stick_y),
    .active     (active)
);

// ----- sim/testbench.sv -----
// Self-checking testbench for the stick dead-zone and circular-clamp unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Output radius the unit is built for; the instance gets the same value.
    localparam int STICK_LIMIT     = 100;
    localparam int SCALE_DIVISOR   = int'(sdcc_pkg::FULL_SCALE);
    localparam int NUM_PROBES      = 25;
    localparam int RANDOM_PHASES   = 8;
    localparam int BEATS_PER_PHASE = 212;
    localparam int MAX_REPORTS     = 10;

    // One conditioned stick position as it leaves the unit.
    typedef struct packed {
        logic signed [sdcc_pkg::FB_W-1:0] x;
        logic signed [sdcc_pkg::FB_W-1:0] y;
        logic                             active;
    } stick_t;

    // One row of the directed sweep: dead zone to run under, the sample, and,
    // where has_value is set, the position worked out by hand.
    typedef struct {
        int dz;
        int rx;
        int ry;
        int fbx;
        int fby;
        int has_value;
        int ex;
        int ey;
        int ea;
    } probe_row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic signed [sdcc_pkg::RAW_W-1:0] raw_x;
    logic signed [sdcc_pkg::RAW_W-1:0] raw_y;
    logic signed [sdcc_pkg::FB_W-1:0]  fallback_x;
    logic signed [sdcc_pkg::FB_W-1:0]  fallback_y;
    logic                              done;
    logic signed [sdcc_pkg::FB_W-1:0]  stick_x;
    logic signed [sdcc_pkg::FB_W-1:0]  stick_y;
    logic                              active;
    logic                              cfg_we;
    logic [sdcc_pkg::DZ_W-1:0]         cfg_data;

    // Positions still owed by the unit, oldest first.
    stick_t pending_sticks[$];
    int     dead_zone_now;
    int     fault_count;

    stick_deadzone_circular_clamp_unit #(
        .OUT_LIMIT (STICK_LIMIT)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .raw_x      (raw_x),
        .raw_y      (raw_y),
        .fallback_x (fallback_x),
        .fallback_y (fallback_y),
        .done       (done),
        .stick_x    (stick_x),
        .stick_y    (stick_y),
        .active     (active),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the unit hangs or drops beats.
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Pull one scaled axis onto the circle: largest q with
    // q^2 * len2 <= m^2 * limit^2, sign of m kept.
    function automatic int pull_onto_circle(int m, longint len2);
        longint room;
        int     q;
        room = longint'(m) * m * STICK_LIMIT * STICK_LIMIT;
        q = 0;
        while (longint'(q + 1) * (q + 1) * len2 <= room)
            q++;
        return (m < 0) ? -q : q;
    endfunction

    // Work out the conditioned position for one raw sample under dead zone dz.
    function automatic stick_t condition_sample(logic signed [sdcc_pkg::RAW_W-1:0] rx,
                                                logic signed [sdcc_pkg::RAW_W-1:0] ry,
                                                logic signed [sdcc_pkg::FB_W-1:0] fx,
                                                logic signed [sdcc_pkg::FB_W-1:0] fy,
                                                int dz);
        int     hx;
        int     hy;
        longint len2;
        stick_t pos;
        hx = int'(rx);
        hy = -int'(ry);      // flip Y so positive is up; -32768 becomes +32768
        if (hx > -dz && hx < dz)
            hx = 0;
        if (hy > -dz && hy < dz)
            hy = 0;
        if (hx == 0 && hy == 0)
        begin
            // Stick at rest: hand the fallback pair through untouched.
            pos.x = fx;
            pos.y = fy;
            pos.active = 1'b0;
        end
        else
        begin
            // Scale to the output range, truncating toward zero.
            hx = (hx * STICK_LIMIT) / SCALE_DIVISOR;
            hy = (hy * STICK_LIMIT) / SCALE_DIVISOR;
            len2 = longint'(hx) * hx + longint'(hy) * hy;
            if (len2 > STICK_LIMIT * STICK_LIMIT)
            begin
                hx = pull_onto_circle(hx, len2);
                hy = pull_onto_circle(hy, len2);
            end
            pos.x = sdcc_pkg::FB_W'(hx);
            pos.y = sdcc_pkg::FB_W'(hy);
            pos.active = 1'b1;
        end
        return pos;
    endfunction

    // Pick one raw axis value, biased toward the interesting regions for dz.
    function automatic logic signed [sdcc_pkg::RAW_W-1:0] pick_axis(int dz);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = int'($urandom_range(0, 65535)) - 32768;
            3, 4:    v = dz + int'($urandom_range(0, 4)) - 2;        // dead-zone edge
            5:
            begin
                case ($urandom_range(0, 3))
                    0:       v = -32768;
                    1:       v = -32767;
                    2:       v = 32766;
                    default: v = 32767;
                endcase
            end
            6:       v = 0;
            7, 8:    v = int'($urandom_range(0, dz));                // inside the dead zone or on its edge
            default: v = int'($urandom_range(20000, 32767));         // long deflection
        endcase
        if (v != -32768 && $urandom_range(0, 1) == 1)
            v = -v;
        return sdcc_pkg::RAW_W'(v);
    endfunction

    // Present one beat and hold it until the unit takes it, then log what is owed.
    task automatic send_beat(input logic signed [sdcc_pkg::RAW_W-1:0] rx,
                             input logic signed [sdcc_pkg::RAW_W-1:0] ry,
                             input logic signed [sdcc_pkg::FB_W-1:0] fx,
                             input logic signed [sdcc_pkg::FB_W-1:0] fy,
                             input stick_t owed);
        start      <= 1'b1;
        raw_x      <= rx;
        raw_y      <= ry;
        fallback_x <= fx;
        fallback_y <= fy;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_sticks.push_back(owed);
    endtask

    // Drop start for a random gap, now and then long enough to cover the pipe.
    task automatic maybe_pause(input bit allowed);
        int gap;
        if (allowed && $urandom_range(0, 99) < 21)
        begin
            gap = ($urandom_range(0, 7) == 0) ? int'($urandom_range(4, 16))
                                              : int'($urandom_range(1, 3));
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the sender until every owed position is back, then let the pipe settle.
    task automatic drain_pipe;
        start <= 1'b0;
        while (pending_sticks.size() != 0)
            @(posedge clk);
        repeat (sdcc_pkg::LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_dead_zone(input int dz);
        cfg_we   <= 1'b1;
        cfg_data <= sdcc_pkg::DZ_W'(dz);
        @(posedge clk);
        cfg_we   <= 1'b0;
        dead_zone_now = dz;
    endtask

    // Directed sweep: resting stick, field extremes, the clamp, dead-zone edges,
    // tiny deflections that scale to zero, and a zero and a full-range dead zone.
    probe_row_t probe_rows [NUM_PROBES] = '{
        '{5000,      0,      0,   12,  -34, 1,   12,  -34, 0},
        '{5000,      0,      0,  127, -128, 1,  127, -128, 0},
        '{5000,   4999,  -4999, -128,  127, 1, -128,  127, 0},
        '{5000,   5000,      0,    0,    0, 1,   15,    0, 1},
        '{5000,  -5000,      0,    0,    0, 1,  -15,    0, 1},
        '{5000,      0,   5000,    3,    4, 1,    0,  -15, 1},
        '{5000,  32767,      0,    1,    1, 1,  100,    0, 1},
        '{5000, -32768,      0,   -1,   -1, 1, -100,    0, 1},
        '{5000,      0, -32768,    9,    9, 1,    0,  100, 1},
        '{5000,      0,  32767,   -9,   -9, 1,    0, -100, 1},
        '{5000,  32767,  32767,   77,   77, 1,   70,  -70, 1},
        '{5000, -32768, -32768,  -77,  -77, 1,  -70,   70, 1},
        '{5000,  20000, -12000,   40,  -40, 0,    0,    0, 0},
        '{5000, -26000,  21000,  -60,   60, 0,    0,    0, 0},
        '{0,         0,      0,   -7,   99, 1,   -7,   99, 0},
        '{0,         1,      0,    5,    6, 1,    0,    0, 1},
        '{0,         0,     -1,    5,    6, 1,    0,    0, 1},
        '{0,       328,      0,    5,    6, 1,    1,    0, 1},
        '{0,      -327,      0,    5,    6, 1,    0,    0, 1},
        '{32767,  32766, -32766,   55,  -66, 1,   55,  -66, 0},
        '{32767,  32767,      0,    0,    0, 1,  100,    0, 1},
        '{32767, -32768,      0,    0,    0, 1, -100,    0, 1},
        '{32767,      0, -32768,    0,    0, 1,    0,  100, 1},
        '{32767,      0,  32767,    0,    0, 1,    0, -100, 1},
        '{32767, -32767,  32767,    0,    0, 1,  -70,  -70, 1}
    };

    initial
    begin : stimulus
        int                                i;
        int                                phase;
        int                                dz;
        int                                guard;
        bit                                calm;
        stick_t                            owed;
        logic signed [sdcc_pkg::RAW_W-1:0] rx;
        logic signed [sdcc_pkg::RAW_W-1:0] ry;
        logic signed [sdcc_pkg::FB_W-1:0]  fx;
        logic signed [sdcc_pkg::FB_W-1:0]  fy;

        rst_n      <= 1'b0;
        start      <= 1'b0;
        raw_x      <= '0;
        raw_y      <= '0;
        fallback_x <= '0;
        fallback_y <= '0;
        cfg_we     <= 1'b0;
        cfg_data   <= '0;
        dead_zone_now = int'(sdcc_pkg::DEAD_RESET);
        fault_count   = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; switch the dead zone only with the pipe empty.
        for (i = 0; i < NUM_PROBES; i++)
        begin
            if (probe_rows[i].dz != dead_zone_now)
            begin
                drain_pipe();
                write_dead_zone(probe_rows[i].dz);
            end
            rx = sdcc_pkg::RAW_W'(probe_rows[i].rx);
            ry = sdcc_pkg::RAW_W'(probe_rows[i].ry);
            fx = sdcc_pkg::FB_W'(probe_rows[i].fbx);
            fy = sdcc_pkg::FB_W'(probe_rows[i].fby);
            if (probe_rows[i].has_value != 0)
            begin
                owed.x      = sdcc_pkg::FB_W'(probe_rows[i].ex);
                owed.y      = sdcc_pkg::FB_W'(probe_rows[i].ey);
                owed.active = probe_rows[i].ea[0];
            end
            else
                owed = condition_sample(rx, ry, fx, fy, dead_zone_now);
            maybe_pause(1'b1);
            send_beat(rx, ry, fx, fy, owed);
        end

        // Random phases, each under its own dead zone; one phase runs back to back.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       dz = 1;
                1:       dz = 32767;
                2:       dz = int'($urandom_range(0, 32767));
                3:       dz = 16384;
                4:       dz = 0;
                5:       dz = int'($urandom_range(0, 800));
                6:       dz = int'(sdcc_pkg::DEAD_RESET);
                default: dz = int'($urandom_range(0, 32767));
            endcase
            drain_pipe();
            write_dead_zone(dz);
            calm = (phase == 3);
            repeat (BEATS_PER_PHASE)
            begin
                rx = pick_axis(dead_zone_now);
                ry = pick_axis(dead_zone_now);
                fx = sdcc_pkg::FB_W'($urandom_range(0, 255));
                fy = sdcc_pkg::FB_W'($urandom_range(0, 255));
                owed = condition_sample(rx, ry, fx, fy, dead_zone_now);
                maybe_pause(!calm);
                send_beat(rx, ry, fx, fy, owed);
            end
        end

        // Wait for the tail, bounded, then give the pipe its latency to go quiet.
        start <= 1'b0;
        guard = 0;
        while (pending_sticks.size() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (sdcc_pkg::LATENCY + 4) @(posedge clk);

        if (pending_sticks.size() != 0)
        begin
            $display("%0d positions never came back", pending_sticks.size());
            fault_count += pending_sticks.size();
        end

        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Check every position the unit strobes out against the oldest one owed.
    always @(posedge clk)
    begin : position_check
        stick_t want;
        if (rst_n && done)
        begin
            if (pending_sticks.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("%0t: unexpected beat x=%0d y=%0d active=%0b",
                             $realtime, stick_x, stick_y, active);
            end
            else
            begin
                want = pending_sticks.pop_front();
                if (stick_x !== want.x || stick_y !== want.y || active !== want.active)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display({"%0t: expected x=%0d y=%0d active=%0b, ",
                                  "got x=%0d y=%0d active=%0b"},
                                 $realtime, want.x, want.y, want.active,
                                 stick_x, stick_y, active);
                end
            end
        end
    end

endmodule
